FILE: hw/rtl/sbpe_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the servo bus packet engine
package sbpe_pkg;

	localparam int CNT_W  = 4;
	localparam int POS_W  = 5;
	localparam int FLAG_W = 5;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_PARAM = 2'd1;
	localparam logic [1:0] REQ_RECV  = 2'd2;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_PARAM  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_M0   = 3'd1;
	localparam logic [2:0] ST_M1   = 3'd2;
	localparam logic [2:0] ST_ID   = 3'd3;
	localparam logic [2:0] ST_CMD  = 3'd4;
	localparam logic [2:0] ST_LEN  = 3'd5;
	localparam logic [2:0] ST_SUM  = 3'd6;

	localparam int FLG_M0  = 0;
	localparam int FLG_M1  = 1;
	localparam int FLG_ID  = 2;
	localparam int FLG_CMD = 3;
	localparam int FLG_LEN = 4;

	localparam logic [POS_W-1:0] POS_M0    = 5'd0;
	localparam logic [POS_W-1:0] POS_M1    = 5'd1;
	localparam logic [POS_W-1:0] POS_ID    = 5'd2;
	localparam logic [POS_W-1:0] POS_LEN   = 5'd3;
	localparam logic [POS_W-1:0] POS_CMD   = 5'd4;
	localparam logic [POS_W-1:0] POS_PARAM = 5'd5;

	localparam logic [7:0] MARK    = 8'h55;
	localparam logic [7:0] LEN_OFS = 8'd3;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [7:0]       servo_id;
		logic [7:0]       command;
		logic [CNT_W-1:0] send_count;
		logic [CNT_W-1:0] reply_count;
		logic [7:0]       data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last;
	} rsp_t;

endpackage

FILE: hw/rtl/servo_bus_packet_engine.sv
`timescale 1ns / 1ps
// servo bus packet engine: frames commands and checks replies
//
// req channel (req_valid, req_stall, req) carries start, parameter and
// received-bus-byte words; rsp channel (rsp_valid, rsp_stall, rsp) returns
// transmit bytes, reply parameter bytes and the reply status.
// a word is taken while the engine is idle; req_stall is high while it is
// still emitting the results of the previous word.
// start: emits 0x55 0x55 id length command, one result per cycle unless the
// receiver stalls; the checksum follows when the send count is zero.
// parameter: one result, two for the last (checksum); none past the send count.
// received byte: taken while idle; the final byte gives the verdict, which
// emits up to MAX_PARAMS buffered parameters (read of the reply ram, then
// output) and the status word.
// results sit in one output register; when the receiver stalls, emission
// pauses and the engine keeps req_stall high until its last result is loaded.
// reset clears all control state; the reply ram needs no clearing since an
// entry is always written before it is read.
module servo_bus_packet_engine
	import sbpe_pkg::*;
#(
	parameter int MAX_PARAMS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_HDR  = 6'b000010,
		S_TXP  = 6'b000100,
		S_RD   = 6'b001000,
		S_EM   = 6'b010000,
		S_STS  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [2:0]       step_q;
	logic [CNT_W-1:0] tx_rem_q;
	logic [7:0]       tx_sum_q;
	logic             rx_armed_q;
	logic [7:0]       exp_id_q;
	logic [7:0]       exp_cmd_q;
	logic [CNT_W-1:0] exp_cnt_q;
	logic [POS_W-1:0] rx_pos_q;
	logic [7:0]       rx_sum_q;
	logic [FLAG_W-1:0] err_q;
	logic [2:0]       st_q;
	logic [CNT_W-1:0] idx_q;
	logic [7:0]       byte_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             acc;
	logic             ld_ok;
	logic             emit;
	rsp_t             word;
	logic [CNT_W-1:0] sc_c;
	logic [CNT_W-1:0] rc_c;
	logic [7:0]       len_c;
	logic [7:0]       hdr_sum_c;
	logic [POS_W-1:0] final_c;
	logic             rx_more;
	logic [FLAG_W-1:0] err_nxt;
	logic [2:0]       verdict;
	logic             ram_we;
	logic [7:0]       ram_rd;

	assign acc       = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign ld_ok     = !rsp_valid_q || !rsp_stall;

	always_comb begin
		sc_c = (32'(req.send_count) > MAX_PARAMS) ? CNT_W'(MAX_PARAMS) : req.send_count;
		rc_c = (32'(req.reply_count) > MAX_PARAMS) ? CNT_W'(MAX_PARAMS) : req.reply_count;
		len_c     = 8'(sc_c) + LEN_OFS;
		hdr_sum_c = req.servo_id + len_c + req.command;
		final_c   = POS_PARAM + POS_W'(exp_cnt_q);
		rx_more   = rx_pos_q < final_c;

		err_nxt = err_q;
		if (rx_pos_q == POS_M0 && req.data_byte != MARK) err_nxt[FLG_M0] = 1'b1;
		if (rx_pos_q == POS_M1 && req.data_byte != MARK) err_nxt[FLG_M1] = 1'b1;
		if (rx_pos_q == POS_ID && req.data_byte != exp_id_q) err_nxt[FLG_ID] = 1'b1;
		if (rx_pos_q == POS_LEN && req.data_byte != (8'(exp_cnt_q) + LEN_OFS)) begin
			err_nxt[FLG_LEN] = 1'b1;
		end
		if (rx_pos_q == POS_CMD && req.data_byte != exp_cmd_q) err_nxt[FLG_CMD] = 1'b1;

		priority if (err_q[FLG_M0]) begin
			verdict = ST_M0;
		end else if (err_q[FLG_M1]) begin
			verdict = ST_M1;
		end else if (err_q[FLG_ID]) begin
			verdict = ST_ID;
		end else if (err_q[FLG_CMD]) begin
			verdict = ST_CMD;
		end else if (err_q[FLG_LEN]) begin
			verdict = ST_LEN;
		end else if (~rx_sum_q != req.data_byte) begin
			verdict = ST_SUM;
		end else begin
			verdict = ST_OK;
		end
	end

	assign ram_we = acc && (req.req_type == REQ_RECV) && rx_armed_q && rx_more
		&& (rx_pos_q >= POS_PARAM);

	sbpe_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PARAMS),
		.AW   (AW)
	) u_reply_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(AW'(rx_pos_q - POS_PARAM)),
		.wr_data(req.data_byte),
		.rd_en  (state_q == S_RD),
		.rd_addr(AW'(idx_q)),
		.rd_data(ram_rd)
	);

	// next result word
	always_comb begin
		word = '{kind: KIND_TX, out_byte: 8'd0, status: ST_OK, last: 1'b0};
		emit = 1'b0;
		unique case (state_q)
			S_HDR: begin
				emit = ld_ok;
				unique case (step_q)
					3'd0, 3'd1: word.out_byte = MARK;
					3'd2: word.out_byte = exp_id_q;
					3'd3: word.out_byte = 8'(tx_rem_q) + LEN_OFS;
					3'd4: word.out_byte = exp_cmd_q;
					3'd5: begin
						word.out_byte = ~tx_sum_q;
						word.last     = 1'b1;
					end
					default: word.out_byte = 8'd0;
				endcase
			end
			S_TXP: begin
				emit = ld_ok;
				if (step_q == 3'd0) begin
					word.out_byte = byte_q;
				end else begin
					word.out_byte = ~tx_sum_q;
					word.last     = 1'b1;
				end
			end
			S_EM: begin
				emit          = ld_ok;
				word.kind     = KIND_PARAM;
				word.out_byte = ram_rd;
			end
			S_STS: begin
				emit        = ld_ok;
				word.kind   = KIND_STATUS;
				word.status = st_q;
				word.last   = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			tx_rem_q    <= '0;
			tx_sum_q    <= '0;
			rx_armed_q  <= 1'b0;
			exp_id_q    <= '0;
			exp_cmd_q   <= '0;
			exp_cnt_q   <= '0;
			rx_pos_q    <= '0;
			rx_sum_q    <= '0;
			err_q       <= '0;
			st_q        <= ST_OK;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (acc) begin
				unique case (req.req_type)
					REQ_START: begin
						tx_sum_q   <= hdr_sum_c;
						tx_rem_q   <= sc_c;
						rx_armed_q <= 1'b1;
						exp_id_q   <= req.servo_id;
						exp_cmd_q  <= req.command;
						exp_cnt_q  <= rc_c;
						rx_pos_q   <= '0;
						rx_sum_q   <= '0;
						err_q      <= '0;
						step_q     <= '0;
						state_q    <= S_HDR;
					end
					REQ_PARAM: begin
						if (tx_rem_q != '0) begin
							tx_sum_q <= tx_sum_q + req.data_byte;
							tx_rem_q <= tx_rem_q - CNT_W'(1);
							step_q   <= '0;
							state_q  <= S_TXP;
						end
					end
					REQ_RECV: begin
						if (rx_armed_q) begin
							if (rx_more) begin
								err_q <= err_nxt;
								if (rx_pos_q >= POS_ID) begin
									rx_sum_q <= rx_sum_q + req.data_byte;
								end
								rx_pos_q <= rx_pos_q + POS_W'(1);
							end else begin
								rx_armed_q <= 1'b0;
								rx_pos_q   <= '0;
								st_q       <= verdict;
								idx_q      <= '0;
								if (verdict == ST_OK && exp_cnt_q != '0) begin
									state_q <= S_RD;
								end else begin
									state_q <= S_STS;
								end
							end
						end
					end
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: ;
				S_HDR: begin
					if (ld_ok) begin
						if (step_q == 3'd5 || (step_q == 3'd4 && tx_rem_q != '0)) begin
							state_q <= S_IDLE;
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				S_TXP: begin
					if (ld_ok) begin
						if (step_q != 3'd0 || tx_rem_q != '0) begin
							state_q <= S_IDLE;
						end else begin
							step_q <= 3'd1;
						end
					end
				end
				S_RD: state_q <= S_EM;
				S_EM: begin
					if (ld_ok) begin
						if (idx_q + CNT_W'(1) == exp_cnt_q) begin
							state_q <= S_STS;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_STS: begin
					if (ld_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byte_q <= req.data_byte;
		end
		if (emit) begin
			rsp_q <= word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hw/rtl/sbpe_ram.sv
`timescale 1ns / 1ps
// generic single-write single-read ram with registered read data
module sbpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/sbpe_chk.sv
`timescale 1ns / 1ps
// port checker for the servo bus packet engine and its bind
module sbpe_chk
	import sbpe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled rsp word changed");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_STATUS |-> rsp.last && rsp.out_byte == 8'd0)
		else $error("status word without last or with data");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != KIND_STATUS |-> rsp.status == ST_OK)
		else $error("status set on a data word");

	a_param_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_PARAM |-> !rsp.last)
		else $error("reply parameter marked last");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.req_type == REQ_START |=> req_stall)
		else $error("start word did not hold off the next word");

endmodule

bind servo_bus_packet_engine sbpe_chk u_sbpe_chk (.*);

FILE: test/sbpe_checker.sv
`timescale 1ns / 1ps
// servo bus packet engine checker: frames and verifies expected words on the response channel
module sbpe_checker
	import sbpe_pkg::*;
#(
	parameter int MAX_PARAMS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	output int unsigned fail_count,
	output int unsigned results_pending
);

	rsp_t             bus_words_due[$];
	logic [3:0]       tx_left;
	logic [7:0]       tx_sum;
	logic             rx_armed;
	logic [7:0]       want_id;
	logic [7:0]       want_cmd;
	logic [3:0]       want_count;
	logic [POS_W-1:0] rx_pos;
	logic [7:0]       rx_sum;
	logic [FLAG_W-1:0] rx_flaws;
	logic [7:0]       reply_mem [MAX_PARAMS];

	function automatic logic [3:0] cap_count(input logic [3:0] c);
		if (int'(c) > MAX_PARAMS) return 4'(MAX_PARAMS);
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("%0t mismatch %s: got %02h want %02h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic queue_word(input logic [1:0] k, input logic [7:0] b, input logic [2:0] s,
		input logic l);
		rsp_t r;
		r.kind = k;
		r.out_byte = b;
		r.status = s;
		r.last = l;
		bus_words_due.push_back(r);
	endtask

	// frame a command or parameter byte or check a reply byte, queueing the words it produces
	task automatic frame_or_check(input req_t w);
		logic [3:0] sc;
		logic [7:0] len_byte;
		logic [7:0] b;
		logic [2:0] v;
		int i;
		b = w.data_byte;
		case (w.req_type)
			REQ_START: begin
				sc = cap_count(w.send_count);
				len_byte = LEN_OFS + 8'(sc);
				queue_word(KIND_TX, MARK, ST_OK, 1'b0);
				queue_word(KIND_TX, MARK, ST_OK, 1'b0);
				queue_word(KIND_TX, w.servo_id, ST_OK, 1'b0);
				queue_word(KIND_TX, len_byte, ST_OK, 1'b0);
				queue_word(KIND_TX, w.command, ST_OK, 1'b0);
				tx_sum = w.servo_id + len_byte + w.command;
				tx_left = sc;
				if (sc == 0) queue_word(KIND_TX, ~tx_sum, ST_OK, 1'b1);
				rx_armed = 1'b1;
				want_id = w.servo_id;
				want_cmd = w.command;
				want_count = cap_count(w.reply_count);
				rx_pos = '0;
				rx_sum = '0;
				rx_flaws = '0;
			end
			REQ_PARAM: begin
				if (tx_left != 0) begin
					tx_sum = tx_sum + b;
					tx_left = tx_left - 4'(1);
					queue_word(KIND_TX, b, ST_OK, 1'b0);
					if (tx_left == 0) queue_word(KIND_TX, ~tx_sum, ST_OK, 1'b1);
				end
			end
			REQ_RECV: begin
				if (rx_armed) begin
					if (rx_pos < POS_PARAM + POS_W'(want_count)) begin
						case (rx_pos)
							POS_M0: if (b != MARK) rx_flaws[FLG_M0] = 1'b1;
							POS_M1: if (b != MARK) rx_flaws[FLG_M1] = 1'b1;
							POS_ID: if (b != want_id) rx_flaws[FLG_ID] = 1'b1;
							POS_LEN: if (b != LEN_OFS + 8'(want_count)) rx_flaws[FLG_LEN] = 1'b1;
							POS_CMD: if (b != want_cmd) rx_flaws[FLG_CMD] = 1'b1;
							default: reply_mem[int'(rx_pos - POS_PARAM)] = b;
						endcase
						if (rx_pos >= POS_ID) rx_sum = rx_sum + b;
						rx_pos = rx_pos + POS_W'(1);
					end else begin
						if (rx_flaws[FLG_M0]) v = ST_M0;
						else if (rx_flaws[FLG_M1]) v = ST_M1;
						else if (rx_flaws[FLG_ID]) v = ST_ID;
						else if (rx_flaws[FLG_CMD]) v = ST_CMD;
						else if (rx_flaws[FLG_LEN]) v = ST_LEN;
						else if (~rx_sum != b) v = ST_SUM;
						else v = ST_OK;
						if (v == ST_OK)
							for (i = 0; i < int'(want_count); i++)
								queue_word(KIND_PARAM, reply_mem[i], ST_OK, 1'b0);
						queue_word(KIND_STATUS, 8'h00, v, 1'b1);
						rx_armed = 1'b0;
						rx_pos = '0;
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			bus_words_due.delete();
			tx_left = '0;
			tx_sum = '0;
			rx_armed = 1'b0;
			want_id = '0;
			want_cmd = '0;
			want_count = '0;
			rx_pos = '0;
			rx_sum = '0;
			rx_flaws = '0;
			fail_count = 0;
			results_pending <= 0;
		end else begin
			if (req_valid && !req_stall) frame_or_check(req);
			if (rsp_valid && !rsp_stall) begin
				if (bus_words_due.size() == 0) begin
					report_mismatch("word with nothing expected", rsp.out_byte, 8'h00);
				end else begin
					want = bus_words_due.pop_front();
					if (rsp.kind !== want.kind)
						report_mismatch("kind", 8'(rsp.kind), 8'(want.kind));
					if (rsp.out_byte !== want.out_byte)
						report_mismatch("out_byte", rsp.out_byte, want.out_byte);
					if (rsp.status !== want.status)
						report_mismatch("status", 8'(rsp.status), 8'(want.status));
					if (rsp.last !== want.last)
						report_mismatch("last", 8'(rsp.last), 8'(want.last));
				end
			end
			results_pending <= bus_words_due.size();
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// servo bus packet engine testbench top: clock, reset, stimulus and verdict
module tb_top;
	import sbpe_pkg::*;

	localparam int MAX_PARAMS = 8;
	localparam int WORDS_TARGET = 400;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int unsigned fail_count;
	int unsigned results_pending;
	int unsigned words_sent = 0;
	int unsigned burst_left = 0;
	bit holding = 1'b0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	int unsigned stall_cycle = 0;

	servo_bus_packet_engine #(.MAX_PARAMS(MAX_PARAMS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	sbpe_checker #(.MAX_PARAMS(MAX_PARAMS)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.fail_count(fail_count),
		.results_pending(results_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver stall pattern: free-running, choppy and long-stall phases
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		if (stall_left == 0) begin
			case ((stall_cycle / 300) % 3)
				0: begin
					rsp_stall <= 1'b0;
					stall_left <= 20;
				end
				1: begin
					rsp_stall <= ($urandom_range(0, 1) == 1);
					stall_left <= $urandom_range(0, 2);
				end
				default: begin
					rsp_stall <= ($urandom_range(0, 3) == 0);
					stall_left <= $urandom_range(0, 25);
				end
			endcase
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic put(input req_t w, input bit counted);
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (counted) words_sent++;
		if (burst_left > 0) begin
			burst_left--;
			holding = 1'b1;
		end else begin
			req_valid <= 1'b0;
			holding = 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3))
				@(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 12);
		end
	endtask

	function automatic req_t any_word(input logic [1:0] t);
		req_t w;
		w.req_type = t;
		w.servo_id = 8'($urandom);
		w.command = 8'($urandom);
		w.send_count = 4'($urandom);
		w.reply_count = 4'($urandom);
		w.data_byte = 8'($urandom);
		return w;
	endfunction

	task automatic start_cmd(input logic [7:0] id, input logic [7:0] cmd,
		input logic [3:0] sc, input logic [3:0] rc);
		req_t w;
		w = any_word(REQ_START);
		w.servo_id = id;
		w.command = cmd;
		w.send_count = sc;
		w.reply_count = rc;
		put(w, 1'b1);
	endtask

	task automatic param_byte(input logic [7:0] b, input bit counted);
		req_t w;
		w = any_word(REQ_PARAM);
		w.data_byte = b;
		put(w, counted);
	endtask

	task automatic bus_byte(input logic [7:0] b, input bit counted);
		req_t w;
		w = any_word(REQ_RECV);
		w.data_byte = b;
		put(w, counted);
	endtask

	// feed a reply frame, optionally damaged in a few bytes or cut short
	task automatic reply_frame(input logic [7:0] id, input logic [7:0] cmd,
		input logic [3:0] rc, input int flaws, input int cut);
		logic [7:0] frame [6 + MAX_PARAMS];
		logic [7:0] sum;
		int n;
		int len;
		int i;
		int p;
		n = (int'(rc) > MAX_PARAMS) ? MAX_PARAMS : int'(rc);
		len = 6 + n;
		frame[0] = MARK;
		frame[1] = MARK;
		frame[2] = id;
		frame[3] = LEN_OFS + 8'(n);
		frame[4] = cmd;
		for (i = 0; i < n; i++) frame[5 + i] = 8'($urandom);
		sum = '0;
		for (i = 2; i < len - 1; i++) sum = sum + frame[i];
		frame[len - 1] = ~sum;
		repeat (flaws) begin
			p = $urandom_range(0, len - 1);
			frame[p] = frame[p] ^ 8'($urandom_range(1, 255));
		end
		for (i = 0; i < len - cut; i++) bus_byte(frame[i], 1'b1);
	endtask

	task automatic random_exchange();
		logic [7:0] id;
		logic [7:0] cmd;
		logic [3:0] sc;
		logic [3:0] rc;
		int n;
		int flaws;
		int cut;
		id = 8'($urandom);
		cmd = 8'($urandom);
		sc = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
		rc = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
		start_cmd(id, cmd, sc, rc);
		n = (int'(sc) > MAX_PARAMS) ? MAX_PARAMS : int'(sc);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(0, n)) param_byte(8'($urandom), 1'b1);
			return;
		end
		repeat (n) param_byte(8'($urandom), 1'b1);
		if ($urandom_range(0, 7) == 0) param_byte(8'($urandom), 1'b0);
		if ($urandom_range(0, 9) == 0) return;
		case ($urandom_range(0, 19))
			0, 1: flaws = $urandom_range(2, 3);
			2, 3, 4, 5, 6: flaws = 1;
			default: flaws = 0;
		endcase
		cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 4) : 0;
		reply_frame(id, cmd, rc, flaws, cut);
		if (cut == 0 && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 2)) bus_byte(8'($urandom), 1'b0);
		if ($urandom_range(0, 19) == 0) put(any_word(REQ_UNUSED), 1'b0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		bus_byte(8'h55, 1'b0);
		start_cmd(8'h00, 8'h00, 4'd0, 4'd0);
		reply_frame(8'h00, 8'h00, 4'd0, 0, 0);
		bus_byte(8'hff, 1'b0);
		param_byte(8'hff, 1'b0);
		put(any_word(REQ_UNUSED), 1'b0);
		start_cmd(8'hff, 8'hff, 4'd15, 4'd1);
		param_byte(8'h00, 1'b1);
		param_byte(8'hff, 1'b1);
		// new start abandons the unfinished packet
		start_cmd(8'ha5, 8'h5a, 4'd2, 4'd0);
		param_byte(8'h80, 1'b1);
		param_byte(8'h7f, 1'b1);
		// every header byte wrong: marker0 wins
		bus_byte(8'h00, 1'b1);
		bus_byte(8'haa, 1'b1);
		bus_byte(8'h11, 1'b1);
		bus_byte(8'h04, 1'b1);
		bus_byte(8'h22, 1'b1);
		bus_byte(8'h00, 1'b1);

		while (words_sent < WORDS_TARGET) random_exchange();

		if (holding) req_valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
